// ===== hw/rtl/tsf_pkg.sv =====
package tsf_pkg;

    // fixed field widths of the item ports
    localparam int IN_SIZE_W = 24;
    localparam int STAMP_W   = 64;
    localparam int BYTES_W   = 28;
    localparam int HELD_W    = 5;

    // largest value bytes_left can show
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // operation codes on func
    localparam logic FUNC_PUSH    = 1'b0;
    localparam logic FUNC_CONSUME = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_DONE
    } tsf_state_t;

    // per-cycle control seen by every cell of the chain
    typedef struct packed {
        logic load;
        logic shift;
    } tsf_cell_ctrl_t;

endpackage

// ===== hw/rtl/tsf_cell.sv =====
module tsf_cell #(
    parameter int SIZE_BITS = 24
) (
    input  logic                            clk,
    input  tsf_pkg::tsf_cell_ctrl_t         ctrl,
    input  logic [SIZE_BITS-1:0]            new_size,
    input  logic [tsf_pkg::STAMP_W-1:0]     new_stamp,
    input  logic [SIZE_BITS-1:0]            nbr_size,
    input  logic [tsf_pkg::STAMP_W-1:0]     nbr_stamp,
    output logic [SIZE_BITS-1:0]            size,
    output logic [tsf_pkg::STAMP_W-1:0]     stamp
);

    logic [SIZE_BITS-1:0]        size_reg;
    logic [tsf_pkg::STAMP_W-1:0] stamp_reg;

    // take a pushed entry, or move one place toward the head on retire
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            size_reg  <= new_size;
            stamp_reg <= new_stamp;
        end
        else if (ctrl.shift)
        begin
            size_reg  <= nbr_size;
            stamp_reg <= nbr_stamp;
        end
    end

    assign size  = size_reg;
    assign stamp = stamp_reg;

endmodule

// ===== hw/rtl/byte_consuming_timestamp_fifo.sv =====
// Timestamp FIFO of up to DEPTH entries (size, timestamp) held in a chain of cells with
// the head always in the first cell. A push passes from IDLE to DONE and a consume from
// IDLE through WORK to DONE; the result is loaded into the output register from DONE.
// The consume loop handles one entry per cycle and retiring an entry shifts the whole
// chain one cell toward the head. One item is in work at a time; in_stall is high from
// acceptance until the result is loaded into the output register, so the next item
// may enter on the following edge while that result still waits to be taken. A result
// that waits under out_stall holds the next result back until it is taken.
module byte_consuming_timestamp_fifo #(
    parameter int DEPTH     = 16,
    parameter int SIZE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [tsf_pkg::IN_SIZE_W-1:0]       entry_size,
    input  logic [tsf_pkg::STAMP_W-1:0]         entry_timestamp,
    input  logic [tsf_pkg::BYTES_W-1:0]         consume_bytes,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [tsf_pkg::STAMP_W-1:0]         head_timestamp,
    output logic                                head_present,
    output logic [tsf_pkg::BYTES_W-1:0]         bytes_left,
    output logic [tsf_pkg::HELD_W-1:0]          entries_held
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TOT_W = SIZE_BITS + CNT_W;
    localparam int CMP_W = (SIZE_BITS > tsf_pkg::BYTES_W) ? SIZE_BITS : tsf_pkg::BYTES_W;
    localparam int SAT_W = (TOT_W > tsf_pkg::BYTES_W) ? TOT_W : tsf_pkg::BYTES_W;

    tsf_pkg::tsf_state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [TOT_W-1:0]              total_reg, total_next;
    logic [SIZE_BITS-1:0]          consumed_reg, consumed_next;
    logic [tsf_pkg::BYTES_W-1:0]   owed_reg, owed_next;
    logic                          acc_reg, acc_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_acc_reg;
    logic [tsf_pkg::STAMP_W-1:0]   out_stamp_reg;
    logic                          out_present_reg;
    logic [tsf_pkg::BYTES_W-1:0]   out_bytes_reg;
    logic [tsf_pkg::HELD_W-1:0]    out_held_reg;

    logic [SIZE_BITS-1:0]          cell_size  [DEPTH];
    logic [tsf_pkg::STAMP_W-1:0]   cell_stamp [DEPTH];
    tsf_pkg::tsf_cell_ctrl_t       cell_ctrl  [DEPTH];

    logic                          in_take;
    logic                          is_push;
    logic                          work_step;
    logic                          retire;
    logic                          out_load;
    logic [SIZE_BITS-1:0]          push_size;
    logic [SIZE_BITS-1:0]          left;
    logic [CMP_W-1:0]              take;

    // handshake
    assign in_stall = (state_reg != tsf_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign is_push  = (func == tsf_pkg::FUNC_PUSH);
    assign out_load = (state_reg == tsf_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // one consume step against the head cell
    assign work_step = (state_reg == tsf_pkg::ST_WORK) && (owed_reg != '0) && (count_reg != '0);
    assign left      = cell_size[0] - consumed_reg;
    assign retire    = (CMP_W'(left) <= CMP_W'(owed_reg));
    assign take      = retire ? CMP_W'(left) : CMP_W'(owed_reg);
    assign push_size = SIZE_BITS'(entry_size);

    // chain of cells, head in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_ctrl[gi].load  = in_take && is_push && (count_reg == CNT_W'(gi));
            assign cell_ctrl[gi].shift = work_step && retire;

            if (gi == DEPTH - 1)
            begin : g_last
                tsf_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_size  (push_size),
                    .new_stamp (entry_timestamp),
                    .nbr_size  (cell_size[gi]),
                    .nbr_stamp (cell_stamp[gi]),
                    .size      (cell_size[gi]),
                    .stamp     (cell_stamp[gi])
                );
            end
            else
            begin : g_mid
                tsf_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_size  (push_size),
                    .new_stamp (entry_timestamp),
                    .nbr_size  (cell_size[gi+1]),
                    .nbr_stamp (cell_stamp[gi+1]),
                    .size      (cell_size[gi]),
                    .stamp     (cell_stamp[gi])
                );
            end
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = is_push ? tsf_pkg::ST_DONE : tsf_pkg::ST_WORK;
                end
            end
            tsf_pkg::ST_WORK:
            begin
                if (!work_step)
                begin
                    state_next = tsf_pkg::ST_DONE;
                end
            end
            tsf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tsf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsf_pkg::ST_IDLE;
            end
        endcase
    end

    // fifo bookkeeping
    always_comb
    begin
        count_next    = count_reg;
        total_next    = total_reg;
        consumed_next = consumed_reg;
        owed_next     = owed_reg;
        acc_next      = acc_reg;
        case (state_reg)
            tsf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (is_push)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            acc_next   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOT_W'(push_size);
                        end
                    end
                    else
                    begin
                        acc_next  = 1'b1;
                        owed_next = consume_bytes;
                    end
                end
            end
            tsf_pkg::ST_WORK:
            begin
                if (work_step)
                begin
                    owed_next  = owed_reg - tsf_pkg::BYTES_W'(take);
                    total_next = total_reg - TOT_W'(take);
                    if (retire)
                    begin
                        count_next    = count_reg - CNT_W'(1);
                        consumed_next = '0;
                    end
                    else
                    begin
                        consumed_next = consumed_reg + SIZE_BITS'(take);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsf_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            consumed_reg  <= '0;
            owed_reg      <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            consumed_reg  <= consumed_next;
            owed_reg      <= owed_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_acc_reg     <= acc_reg;
            out_present_reg <= (count_reg != '0);
            out_stamp_reg   <= (count_reg != '0) ? cell_stamp[0] : '1;
            out_bytes_reg   <= (SAT_W'(total_reg) > SAT_W'(tsf_pkg::BYTES_MAX))
                               ? tsf_pkg::BYTES_MAX : tsf_pkg::BYTES_W'(total_reg);
            out_held_reg    <= tsf_pkg::HELD_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_acc_reg;
    assign head_timestamp = out_stamp_reg;
    assign head_present   = out_present_reg;
    assign bytes_left     = out_bytes_reg;
    assign entries_held   = out_held_reg;

endmodule

// ===== hw/rtl/tsf_checker.sv =====
module tsf_checker #(
    parameter int DEPTH = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              accepted,
    input logic [tsf_pkg::STAMP_W-1:0]       head_timestamp,
    input logic                              head_present,
    input logic [tsf_pkg::BYTES_W-1:0]       bytes_left,
    input logic [tsf_pkg::HELD_W-1:0]        entries_held
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entries_held) && $stable(bytes_left))
        else $error("stalled item changed");

    // presence flag matches entry count
    a_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_present == (entries_held != '0)))
        else $error("head_present disagrees with entries_held");

    // empty fifo shows all-ones stamp and no bytes
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_present |-> (head_timestamp == '1) && (bytes_left == '0))
        else $error("empty fifo result malformed");

    // a refused push only happens when full
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (entries_held == tsf_pkg::HELD_W'(DEPTH)))
        else $error("push refused while not full");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while busy");

endmodule

bind byte_consuming_timestamp_fifo tsf_checker #(.DEPTH(DEPTH)) u_tsf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .head_timestamp (head_timestamp),
    .head_present   (head_present),
    .bytes_left     (bytes_left),
    .entries_held   (entries_held)
);
